// ----- rtl/core/lmsr_pkg.sv -----
package lmsr_pkg;

	localparam int DEVICES = 4;
	localparam int BUF_LEN = DEVICES * 8;
	localparam int DEV_W   = (DEVICES > 1) ? $clog2(DEVICES) : 1;

	localparam logic [1:0] CMD_PUSH    = 2'd0;
	localparam logic [1:0] CMD_CLEAR   = 2'd1;
	localparam logic [1:0] CMD_REFRESH = 2'd2;

	localparam logic [DEV_W-1:0] DEV_LAST = DEV_W'(DEVICES - 1);
	localparam logic [2:0]       ROW_LAST = 3'd7;

	typedef logic [7:0] col_t;

	typedef struct packed {
		logic             push;
		logic             clear;
		logic             load;
		logic             rot_blk;
		logic [2:0]       row;
		logic [DEV_W-1:0] dev;
		logic             last;
	} ctl_t;

endpackage

// ----- rtl/core/lmsr_ifs.sv -----
interface lmsr_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] cmd;
	logic [7:0] column_bits;

	modport source (output valid, output cmd, output column_bits, input ready);
	modport sink   (input valid, input cmd, input column_bits, output ready);
endinterface

interface lmsr_frame_if;
	logic       valid;
	logic       ready;
	logic [1:0] chain_position;
	logic [3:0] register_address;
	logic [7:0] register_data;
	logic       last;

	modport source (output valid, output chain_position, output register_address,
		output register_data, output last, input ready);
	modport sink   (input valid, input chain_position, input register_address,
		input register_data, input last, output ready);
endinterface

interface lmsr_cfg_if;
	logic valid;
	logic ready;
	logic rotate_enable;

	modport source (output valid, output rotate_enable, input ready);
	modport sink   (input valid, input rotate_enable, output ready);
endinterface

// ----- rtl/core/lmsr_ctrl.sv -----
module lmsr_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	input  logic [1:0]       req_cmd,
	output logic             req_ready,
	output logic             out_valid,
	input  logic             out_ready,
	output lmsr_pkg::ctl_t   ctl
);
	import lmsr_pkg::*;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_RUN  = 1'b1;

	logic             st_q;
	logic [2:0]       row_q;
	logic [DEV_W-1:0] dev_q;
	logic             ov_q;
	logic             accept;
	logic             last;

	assign req_ready = (st_q == ST_IDLE);
	assign accept    = req_valid && req_ready;
	assign last      = (dev_q == DEV_LAST) && (row_q == ROW_LAST);
	assign out_valid = ov_q;

	always_comb begin
		ctl         = '0;
		ctl.push    = accept && (req_cmd == CMD_PUSH);
		ctl.clear   = accept && (req_cmd == CMD_CLEAR);
		ctl.load    = (st_q == ST_RUN) && (!ov_q || out_ready);
		ctl.rot_blk = ctl.load && (row_q == ROW_LAST);
		ctl.row     = row_q;
		ctl.dev     = dev_q;
		ctl.last    = last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= ST_IDLE;
			row_q <= '0;
			dev_q <= '0;
			ov_q  <= 1'b0;
		end else begin
			unique case (st_q)
				ST_IDLE: begin
					if (accept && (req_cmd == CMD_REFRESH)) begin
						st_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (ctl.load) begin
						row_q <= row_q + 3'd1;
						if (row_q == ROW_LAST) begin
							dev_q <= last ? '0 : dev_q + 1'b1;
						end
						if (last) begin
							st_q <= ST_IDLE;
						end
					end
				end
				default: st_q <= ST_IDLE;
			endcase
			if (ctl.load) begin
				ov_q <= 1'b1;
			end else if (out_ready) begin
				ov_q <= 1'b0;
			end
		end
	end

`ifndef SYNTHESIS
	a_idle_parked: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_IDLE |-> row_q == '0 && dev_q == '0)
		else $error("counters not parked while idle");
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.load && last |=> st_q == ST_IDLE && ov_q)
		else $error("refresh did not end after final frame");
	a_row_step: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.load |=> row_q == $past(row_q) + 3'd1)
		else $error("row counter did not advance");
	a_no_cmd_run: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_RUN |-> !ctl.push && !ctl.clear)
		else $error("buffer command during refresh");
`endif

endmodule

// ----- rtl/core/lmsr_dp.sv -----
module lmsr_dp (
	input  logic           clk,
	input  logic           arst_n,
	input  lmsr_pkg::ctl_t ctl,
	input  lmsr_pkg::col_t column_bits,
	input  logic           cfg_we,
	input  logic           cfg_rotate,
	output logic [1:0]     chain_position,
	output logic [3:0]     register_address,
	output logic [7:0]     register_data,
	output logic           last
);
	import lmsr_pkg::*;

	col_t             buf_q [BUF_LEN];
	col_t             blk   [8];
	logic             rot_q;
	logic [DEV_W-1:0] pos;
	logic [7:0]       tdata;
	logic [1:0]       pos_q;
	logic [3:0]       addr_q;
	logic [7:0]       data_q;
	logic             last_q;

	always_comb begin
		for (int i = 0; i < 8; i++) begin
			blk[i]   = buf_q[i];
			tdata[i] = buf_q[i][ctl.row];
		end
		pos = rot_q ? (DEV_LAST - ctl.dev) : ctl.dev;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot_q <= 1'b1;
			for (int i = 0; i < BUF_LEN; i++) begin
				buf_q[i] <= '0;
			end
		end else begin
			if (cfg_we) begin
				rot_q <= cfg_rotate;
			end
			if (ctl.clear) begin
				for (int i = 0; i < BUF_LEN; i++) begin
					buf_q[i] <= '0;
				end
			end else if (ctl.push) begin
				for (int i = 0; i < BUF_LEN - 1; i++) begin
					buf_q[i] <= buf_q[i + 1];
				end
				buf_q[BUF_LEN - 1] <= column_bits;
			end else if (ctl.rot_blk) begin
				for (int i = 0; i < BUF_LEN; i++) begin
					buf_q[i] <= buf_q[(i + 8) % BUF_LEN];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			pos_q  <= 2'(pos);
			addr_q <= rot_q ? (4'd8 - {1'b0, ctl.row}) : ({1'b0, ctl.row} + 4'd1);
			data_q <= rot_q ? tdata : blk[ctl.row];
			last_q <= ctl.last;
		end
	end

	assign chain_position   = pos_q;
	assign register_address = addr_q;
	assign register_data    = data_q;
	assign last             = last_q;

endmodule

// ----- rtl/core/led_matrix_scroll_refresh_unit.sv -----
// channel | dir | handshake     | payload
// req     | in  | valid / ready | cmd[1:0], column_bits[7:0]
// frame   | out | valid / ready | chain_position[1:0], register_address[3:0],
//         |     |               | register_data[7:0], last
// cfg     | in  | valid / ready | rotate_enable
//
// Push and clear are applied to the buffer when accepted; an accepted refresh
// then sends one frame per cycle while the frame output is not stalled, set by
// the row/device sequencer walking the buffer block by block.
// A stalled frame output holds the sequencer; no request is taken mid-refresh.
// arst_n clears the column buffer and sets rotate_enable.
module led_matrix_scroll_refresh_unit (
	input  logic clk,
	input  logic arst_n,
	lmsr_req_if.sink     req,
	lmsr_frame_if.source frame,
	lmsr_cfg_if.sink     cfg
);
	import lmsr_pkg::*;

	ctl_t ctl;

	assign cfg.ready = 1'b1;

	lmsr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_cmd   (req.cmd),
		.req_ready (req.ready),
		.out_valid (frame.valid),
		.out_ready (frame.ready),
		.ctl       (ctl)
	);

	lmsr_dp u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.ctl              (ctl),
		.column_bits      (req.column_bits),
		.cfg_we           (cfg.valid),
		.cfg_rotate       (cfg.rotate_enable),
		.chain_position   (frame.chain_position),
		.register_address (frame.register_address),
		.register_data    (frame.register_data),
		.last             (frame.last)
	);

endmodule
